[design/lpd_pkg.sv]
package lpd_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_W = 8;
  localparam int CHAN_W   = 3;
  localparam int GAP_W    = 16;
  localparam int IDX_W    = 6;
  localparam int OUT_CNT_W = 16;
  localparam int FILT_W   = 15;
  localparam int SHIFT_W  = 32;
  localparam int HIST_LEN = 6;
  localparam int POLY_SLOTS = 64;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register byte addresses
  localparam logic [3:0] ADDR_CHANNEL   = 4'h0;
  localparam logic [3:0] ADDR_MIN_GAP   = 4'h4;
  localparam logic [3:0] ADDR_BURST_GAP = 4'h8;

  // Register reset values
  localparam logic [CHAN_W-1:0] CHANNEL_RESET   = 3'd0;
  localparam logic [GAP_W-1:0]  MIN_GAP_RESET   = 16'd10;
  localparam logic [GAP_W-1:0]  BURST_GAP_RESET = 16'd100;

  // FIR taps scaled by 10000, oldest first
  localparam logic signed [FILT_W-1:0] FIR_COEF [HIST_LEN] = '{
    15'sd280, 15'sd1597, 15'sd2779, 15'sd3396, 15'sd2779, 15'sd1597
  };

  // Candidate polynomials; unused slots are zero
  localparam logic [SHIFT_W-1:0] POLY_TABLE [POLY_SLOTS] = '{
    32'h0001D258, 32'h00017E04, 32'h0001FF6B, 32'h00013F67,
    32'h0001B9EE, 32'h000198D1, 32'h000178C7, 32'h00018A55,
    32'h00015777, 32'h0001D911, 32'h00015769, 32'h0001991F,
    32'h00012BD0, 32'h0001CF73, 32'h0001365D, 32'h000197F5,
    32'h000194A0, 32'h0001B279, 32'h00013A34, 32'h0001AE41,
    32'h000180D4, 32'h00017891, 32'h00012E64, 32'h00017C72,
    32'h00019C6D, 32'h00013F32, 32'h0001AE14, 32'h00014E76,
    32'h00013C97, 32'h000130CB, 32'h00013750, 32'h0001CB8D,
    32'h000D3675, 32'h00090C2D, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0
  };

  // Work handed from front to back
  typedef enum logic {
    CMD_SHIFT,
    CMD_REPORT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    bit_in;
  } cmd_t;

  // Back-end sequencer
  typedef enum logic {
    BK_RUN,
    BK_SEARCH
  } back_state_t;

endpackage

[design/lpd_front.sv]
module lpd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lpd_pkg::SAMPLE_W-1:0] sample_byte,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lpd_pkg::CHAN_W-1:0]   channel_select,
  input  logic [lpd_pkg::GAP_W-1:0]    min_symbol_gap,
  input  logic [lpd_pkg::GAP_W-1:0]    burst_gap,
  input  logic                         q_full,
  output logic                         push,
  output lpd_pkg::cmd_t                push_cmd
);

  // FIR history: per tap a nonzero flag and a sign (oldest at index 0)
  logic [lpd_pkg::HIST_LEN-1:0] hist_val;
  logic [lpd_pkg::HIST_LEN-1:0] hist_neg;
  logic [lpd_pkg::HIST_LEN-1:0] hist_val_next;
  logic [lpd_pkg::HIST_LEN-1:0] hist_neg_next;
  logic signed [lpd_pkg::FILT_W-1:0] prev_filt;
  logic signed [lpd_pkg::FILT_W-1:0] filt;
  logic [lpd_pkg::GAP_W-1:0] gap;
  logic [lpd_pkg::GAP_W-1:0] gap_inc;
  logic take;
  logic x_pos;
  logic sign_edge;
  logic fire;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // Channel pick, FIR and edge classification
  always_comb begin
    logic signed [lpd_pkg::FILT_W-1:0] acc;
    x_pos         = sample_byte[channel_select];
    hist_val_next = {1'b1, hist_val[lpd_pkg::HIST_LEN-1:1]};
    hist_neg_next = {~x_pos, hist_neg[lpd_pkg::HIST_LEN-1:1]};
    acc = '0;
    for (int j = 0; j < lpd_pkg::HIST_LEN; j++) begin
      if (hist_val_next[j]) begin
        if (hist_neg_next[j]) acc = acc - lpd_pkg::FIR_COEF[j];
        else acc = acc + lpd_pkg::FIR_COEF[j];
      end
    end
    filt = acc;

    sign_edge = (x_pos && prev_filt[lpd_pkg::FILT_W-1]) ||
                (!x_pos && !prev_filt[lpd_pkg::FILT_W-1] && (prev_filt != '0));
    gap_inc   = (&gap) ? gap : gap + 1'b1;
    fire      = sign_edge && (gap_inc > min_symbol_gap);

    push            = take && fire;
    push_cmd.op     = (gap_inc > burst_gap) ? lpd_pkg::CMD_REPORT : lpd_pkg::CMD_SHIFT;
    push_cmd.bit_in = !filt[lpd_pkg::FILT_W-1] && (filt != '0);
  end

  // Front state
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_val  <= '0;
      hist_neg  <= '0;
      prev_filt <= '0;
      gap       <= '0;
    end else if (take) begin
      hist_val  <= hist_val_next;
      hist_neg  <= hist_neg_next;
      prev_filt <= filt;
      gap       <= fire ? '0 : gap_inc;
    end
  end

endmodule

[design/lpd_queue.sv]
module lpd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lpd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output lpd_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = (lpd_pkg::QUEUE_DEPTH > 1) ? $clog2(lpd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lpd_pkg::QUEUE_DEPTH + 1);

  lpd_pkg::cmd_t slots [lpd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(lpd_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(lpd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(lpd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

[design/lpd_back.sv]
module lpd_back #(
  parameter int NUM_POLYS   = 34,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpd_pkg::cmd_t                 head,
  input  logic                          empty,
  output logic                          pop,
  output logic [lpd_pkg::IDX_W-1:0]     best_index,
  output logic [lpd_pkg::OUT_CNT_W-1:0] best_count,
  output logic                          data_bit,
  output logic                          out_valid,
  input  logic                          out_stall
);

  localparam int LEVELS = (NUM_POLYS > 1) ? $clog2(NUM_POLYS) : 1;
  localparam int LEAVES = 1 << LEVELS;
  localparam int WAIT_W = $clog2(LEVELS + 1);
  localparam int EXT_W  = (COUNT_WIDTH > lpd_pkg::OUT_CNT_W) ? COUNT_WIDTH : lpd_pkg::OUT_CNT_W;

  lpd_pkg::back_state_t state, state_next;
  logic [WAIT_W-1:0] wait_cnt, wait_cnt_next;
  logic [lpd_pkg::SHIFT_W-1:0] shift_reg;
  logic [lpd_pkg::SHIFT_W-1:0] shift_next;
  logic [COUNT_WIDTH-1:0] counts [NUM_POLYS];
  logic do_shift;
  logic do_report;
  logic out_free;

  // Argmax tree
  logic [COUNT_WIDTH-1:0]   leaf_cnt [LEAVES];
  logic [lpd_pkg::IDX_W-1:0] leaf_idx [LEAVES];
  logic [COUNT_WIDTH-1:0]   node_cnt [LEVELS][LEAVES/2];
  logic [lpd_pkg::IDX_W-1:0] node_idx [LEVELS][LEAVES/2];
  logic [EXT_W-1:0] best_ext;

  assign out_free   = !out_valid || !out_stall;
  assign shift_next = {shift_reg[lpd_pkg::SHIFT_W-2:0], head.bit_in};

  // Sequencer: a shift at the head is popped at once, a report waits for the tree
  always_comb begin
    state_next    = state;
    wait_cnt_next = wait_cnt;
    pop           = 1'b0;
    do_shift      = 1'b0;
    do_report     = 1'b0;
    unique case (state)
      lpd_pkg::BK_RUN: begin
        if (!empty) begin
          if (head.op == lpd_pkg::CMD_SHIFT) begin
            pop      = 1'b1;
            do_shift = 1'b1;
          end else begin
            state_next    = lpd_pkg::BK_SEARCH;
            wait_cnt_next = WAIT_W'(1);
          end
        end
      end
      lpd_pkg::BK_SEARCH: begin
        if (wait_cnt == WAIT_W'(LEVELS)) begin
          if (out_free) begin
            pop        = 1'b1;
            do_report  = 1'b1;
            state_next = lpd_pkg::BK_RUN;
          end
        end else begin
          wait_cnt_next = wait_cnt + 1'b1;
        end
      end
      default: state_next = lpd_pkg::BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lpd_pkg::BK_RUN;
      wait_cnt <= '0;
    end else begin
      state    <= state_next;
      wait_cnt <= wait_cnt_next;
    end
  end

  // Demodulated bit register
  always_ff @(posedge clk) begin
    if (rst) shift_reg <= '0;
    else if (do_report) shift_reg <= '0;
    else if (do_shift) shift_reg <= shift_next;
  end

  // One saturating hit counter per polynomial
  for (genvar j = 0; j < NUM_POLYS; j++) begin : g_cnt
    logic even;
    assign even = ~^(shift_next & lpd_pkg::POLY_TABLE[j]);
    always_ff @(posedge clk) begin
      if (rst || do_report) counts[j] <= '0;
      else if (do_shift && even && !(&counts[j])) counts[j] <= counts[j] + 1'b1;
    end
  end

  // Tree leaves; padding slots count zero and never win a tie
  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < NUM_POLYS) begin : g_real
      assign leaf_cnt[j] = counts[j];
    end else begin : g_pad
      assign leaf_cnt[j] = '0;
    end
    assign leaf_idx[j] = lpd_pkg::IDX_W'(j);
  end

  // Registered compare levels; right side wins only on a strictly larger count
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    for (genvar n = 0; n < (LEAVES >> (l + 1)); n++) begin : g_node
      logic [COUNT_WIDTH-1:0]    lc, rc;
      logic [lpd_pkg::IDX_W-1:0] li, ri;
      if (l == 0) begin : g_first
        assign lc = leaf_cnt[2*n];
        assign rc = leaf_cnt[2*n+1];
        assign li = leaf_idx[2*n];
        assign ri = leaf_idx[2*n+1];
      end else begin : g_inner
        assign lc = node_cnt[l-1][2*n];
        assign rc = node_cnt[l-1][2*n+1];
        assign li = node_idx[l-1][2*n];
        assign ri = node_idx[l-1][2*n+1];
      end
      always_ff @(posedge clk) begin
        if (rc > lc) begin
          node_cnt[l][n] <= rc;
          node_idx[l][n] <= ri;
        end else begin
          node_cnt[l][n] <= lc;
          node_idx[l][n] <= li;
        end
      end
    end
  end

  assign best_ext = EXT_W'(node_cnt[LEVELS-1][0]);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (do_report) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (do_report) begin
      best_index <= node_idx[LEVELS-1][0];
      best_count <= best_ext[lpd_pkg::OUT_CNT_W-1:0];
      data_bit   <= node_idx[LEVELS-1][0][0];
    end
  end

endmodule

[design/lfsr_polynomial_detector_unit.sv]
// Throughput: one sample item per cycle while the queue is not full; a non-edge or
// shifting edge never holds the input itself. A reporting edge keeps the back end busy
// while the argmax tree settles through its registered compare levels, plus any output
// stall; the two-entry queue holds the report and one more edge, then stalls.
// Reset (rst, synchronous, active high) clears filter history, gap, bit register, counters,
// the queue and output valid, and loads channel 0, minimum gap 10, burst gap 100.
module lfsr_polynomial_detector_unit #(
  parameter int NUM_POLYS   = 34,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // sample channel
  input  logic [7:0]  sample_byte,
  input  logic        in_valid,
  output logic        in_stall,
  // report channel
  output logic [5:0]  best_index,
  output logic [15:0] best_count,
  output logic        data_bit,
  output logic        out_valid,
  input  logic        out_stall,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [lpd_pkg::CHAN_W-1:0] channel_select;
  logic [lpd_pkg::GAP_W-1:0]  min_symbol_gap;
  logic [lpd_pkg::GAP_W-1:0]  burst_gap;
  logic cfg_wr;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  lpd_pkg::cmd_t push_cmd;
  lpd_pkg::cmd_t head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= lpd_pkg::CHANNEL_RESET;
      min_symbol_gap <= lpd_pkg::MIN_GAP_RESET;
      burst_gap      <= lpd_pkg::BURST_GAP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr)
        lpd_pkg::ADDR_CHANNEL:   channel_select <= pwdata[lpd_pkg::CHAN_W-1:0];
        lpd_pkg::ADDR_MIN_GAP:   min_symbol_gap <= pwdata[lpd_pkg::GAP_W-1:0];
        lpd_pkg::ADDR_BURST_GAP: burst_gap      <= pwdata[lpd_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr)
      lpd_pkg::ADDR_CHANNEL:   prdata = 32'(channel_select);
      lpd_pkg::ADDR_MIN_GAP:   prdata = 32'(min_symbol_gap);
      lpd_pkg::ADDR_BURST_GAP: prdata = 32'(burst_gap);
      default:                 prdata = '0;
    endcase
  end

  lpd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .sample_byte    (sample_byte),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .channel_select (channel_select),
    .min_symbol_gap (min_symbol_gap),
    .burst_gap      (burst_gap),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  lpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  lpd_back #(
    .NUM_POLYS   (NUM_POLYS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .best_index (best_index),
    .best_count (best_count),
    .data_bit   (data_bit),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule
